@@ rtl/abst_pkg.sv @@
package abst_pkg;

    localparam int KEY_W  = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_ROOM   = 2'd3;

    typedef logic [1:0] step_t;

    localparam step_t STEP_CLEAR = 2'd0;
    localparam step_t STEP_IDLE  = 2'd1;
    localparam step_t STEP_WALK  = 2'd2;
    localparam step_t STEP_EMIT  = 2'd3;

    localparam int UC_DEPTH = 4;

    // Condition that selects the jump target; otherwise the next field is taken.
    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_CLR_BUSY = 3'd1,
        COND_NO_REQ   = 3'd2,
        COND_DESCEND  = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic walk;
        logic emit;
    } ctl_t;

    typedef struct packed {
        ctl_t  ctl;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    typedef struct packed {
        logic clr_last;
        logic descend;
        logic out_free;
    } dp_flags_t;

    localparam ucode_t UCODE [UC_DEPTH] = '{
        '{ctl: '{clear: 1'b1, accept: 1'b0, walk: 1'b0, emit: 1'b0},
          cond: COND_CLR_BUSY, jump: STEP_CLEAR, next: STEP_IDLE},
        '{ctl: '{clear: 1'b0, accept: 1'b1, walk: 1'b0, emit: 1'b0},
          cond: COND_NO_REQ,   jump: STEP_IDLE,  next: STEP_WALK},
        '{ctl: '{clear: 1'b0, accept: 1'b0, walk: 1'b1, emit: 1'b0},
          cond: COND_DESCEND,  jump: STEP_WALK,  next: STEP_EMIT},
        '{ctl: '{clear: 1'b0, accept: 1'b0, walk: 1'b0, emit: 1'b1},
          cond: COND_OUT_BUSY, jump: STEP_EMIT,  next: STEP_IDLE}
    };

endpackage

@@ rtl/abst_sequencer.sv @@
module abst_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  abst_pkg::dp_flags_t flags,
    output abst_pkg::ctl_t      ctl
);
    import abst_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   cond_true;

    assign word = UCODE[pc_reg];
    assign ctl  = word.ctl;

    always_comb
    begin
        case (word.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_CLR_BUSY: cond_true = !flags.clr_last;
            COND_NO_REQ:   cond_true = !req_valid;
            COND_DESCEND:  cond_true = flags.descend;
            COND_OUT_BUSY: cond_true = !flags.out_free;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? word.jump : word.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/abst_datapath.sv @@
module abst_datapath #(
    parameter int LEVELS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  abst_pkg::ctl_t                      ctl,
    input  logic                                req_valid,
    input  logic                                op,
    input  logic signed [abst_pkg::KEY_W-1:0]   key,
    output abst_pkg::dp_flags_t                 flags,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [abst_pkg::STAT_W-1:0]         status,
    output logic [abst_pkg::SLOT_W-1:0]         slot
);
    import abst_pkg::*;

    localparam int SLOTS = 1 << LEVELS;
    localparam int IDX_W = LEVELS + 2;

    logic signed [KEY_W-1:0] mem [SLOTS];

    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic signed [KEY_W-1:0] key_reg;
    logic                    op_reg;
    logic signed [KEY_W-1:0] rdata_reg;
    logic [STAT_W-1:0]       res_status_reg;
    logic [STAT_W-1:0]       res_status_next;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [SLOT_W-1:0]       res_slot_next;
    logic                    rsp_valid_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [SLOT_W-1:0]       slot_reg;

    logic                    take;
    logic                    oor;
    logic                    empty;
    logic                    hit;
    logic                    go_left;
    logic                    descend;
    logic                    out_free;
    logic [IDX_W-1:0]        child;
    logic                    we;
    logic                    re;
    logic [LEVELS-1:0]       raddr;
    logic signed [KEY_W-1:0] wdata;
    logic [LEVELS+SLOT_W-1:0] slot_ext;

    assign take     = ctl.accept && req_valid;
    // Any bit above the slot index marks a walk that has stepped past the last slot.
    assign oor      = |idx_reg[IDX_W-1:LEVELS];
    assign empty    = (rdata_reg == '0);
    assign hit      = (op_reg == OP_SEARCH) && (rdata_reg == key_reg);
    assign go_left  = (key_reg < rdata_reg);
    assign child    = {1'b0, idx_reg[LEVELS-1:0], 1'b0} + IDX_W'(go_left ? 1 : 2);
    assign descend  = ctl.walk && !oor && !empty && !hit;
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign slot_ext = {{SLOT_W{1'b0}}, idx_reg[LEVELS-1:0]};

    assign flags.clr_last = &idx_reg[LEVELS-1:0];
    assign flags.descend  = !oor && !empty && !hit;
    assign flags.out_free = out_free;

    assign we    = ctl.clear || (ctl.walk && !oor && empty && (op_reg == OP_INSERT));
    assign wdata = ctl.clear ? '0 : key_reg;
    assign re    = take || descend;
    assign raddr = take ? '0 : child[LEVELS-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.clear)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else if (take)
        begin
            idx_next = '0;
        end
        else if (descend)
        begin
            idx_next = child;
        end
    end

    always_comb
    begin
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        if (ctl.walk)
        begin
            if (oor)
            begin
                res_status_next = (op_reg == OP_SEARCH) ? ST_NOT_FOUND : ST_NO_ROOM;
                res_slot_next   = '0;
            end
            else if (empty)
            begin
                if (op_reg == OP_INSERT)
                begin
                    res_status_next = ST_INSERTED;
                    res_slot_next   = slot_ext[SLOT_W-1:0];
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_slot_next   = '0;
                end
            end
            else if (hit)
            begin
                res_status_next = ST_FOUND;
                res_slot_next   = slot_ext[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg[LEVELS-1:0]] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= key;
            op_reg  <= op;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (ctl.emit && out_free)
        begin
            status_reg <= res_status_reg;
            slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (ctl.emit && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

endmodule

@@ rtl/array_bst_insert_search_top.sv @@
// Binary search tree kept in one store of 2^LEVELS signed 32-bit slots in
// heap order; a slot holding zero is empty.
// Request channel (req_valid/req_ready, op, key): op 0 inserts key, op 1
// searches for it. Response channel (rsp_valid/rsp_ready, status, slot)
// returns exactly one item per request: 0 inserted, 1 found, 2 not found,
// 3 no room on the path, with the slot written or found (0 otherwise).
// One request is worked at a time by a four-step microprogram: it takes the
// item, walks the tree one slot at a time (each slot is one read of the
// single-port store; a walk inspects at most LEVELS slots, with one more pass
// when it steps past the last slot), and loads the response register; only
// then can the next request be taken.
// After reset the store is cleared one slot per cycle, all 2^LEVELS slots
// (1024 by default), with req_ready held low.
// A finished response waits in the output register while the next request
// is accepted and walked; that walk stalls before its own response only if
// the receiver has still not taken the previous one.
module array_bst_insert_search_top #(
    parameter int LEVELS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                op,
    input  logic signed [abst_pkg::KEY_W-1:0]   key,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [abst_pkg::STAT_W-1:0]         status,
    output logic [abst_pkg::SLOT_W-1:0]         slot
);
    import abst_pkg::*;

    ctl_t      ctl;
    dp_flags_t flags;

    assign req_ready = ctl.accept;

    abst_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .flags     (flags),
        .ctl       (ctl)
    );

    abst_datapath #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_valid (req_valid),
        .op        (op),
        .key       (key),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .slot      (slot)
    );

endmodule

@@ bench/array_bst_insert_search_top_tb.sv @@
module array_bst_insert_search_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import abst_pkg::*;

    localparam int TREE_LEVELS  = 10;
    localparam int TREE_SLOTS   = 1 << TREE_LEVELS;
    localparam int RANDOM_ITEMS = 1926;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 400;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ALL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0] outcome;
        logic [SLOT_W-1:0] at_slot;
    } verdict_t;

    typedef struct packed {
        logic             req_op;
        logic [KEY_W-1:0] req_key;
        verdict_t         want;
    } pending_t;

    typedef struct packed {
        logic             req_op;
        logic [KEY_W-1:0] req_key;
        logic             pinned;
        verdict_t         want;
    } dir_row_t;

    localparam int N_DIRECTED = 24;

    // Rows with pinned set carry a result that can be read off directly;
    // the rest are left to the tree walk below.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_SEARCH, 32'd5,    1'b1, '{ST_NOT_FOUND, 10'd0}},
        '{OP_SEARCH, 32'd0,    1'b1, '{ST_NOT_FOUND, 10'd0}},
        '{OP_INSERT, 32'd0,    1'b1, '{ST_INSERTED,  10'd0}},
        '{OP_INSERT, 32'd1000, 1'b1, '{ST_INSERTED,  10'd0}},
        '{OP_SEARCH, 32'd1000, 1'b1, '{ST_FOUND,     10'd0}},
        '{OP_INSERT, KEY_MAX,  1'b1, '{ST_INSERTED,  10'd2}},
        '{OP_INSERT, KEY_MIN,  1'b1, '{ST_INSERTED,  10'd1}},
        '{OP_SEARCH, KEY_MIN,  1'b1, '{ST_FOUND,     10'd1}},
        '{OP_SEARCH, KEY_MAX,  1'b1, '{ST_FOUND,     10'd2}},
        '{OP_INSERT, 32'd1000, 1'b0, '0},
        '{OP_INSERT, 32'd0,    1'b0, '0},
        '{OP_SEARCH, 32'd0,    1'b1, '{ST_NOT_FOUND, 10'd0}},
        '{OP_INSERT, 32'd1001, 1'b0, '0},
        '{OP_INSERT, 32'd1002, 1'b0, '0},
        '{OP_INSERT, 32'd1003, 1'b0, '0},
        '{OP_INSERT, 32'd1004, 1'b0, '0},
        '{OP_INSERT, 32'd1005, 1'b0, '0},
        '{OP_INSERT, 32'd1006, 1'b0, '0},
        '{OP_INSERT, 32'd1007, 1'b0, '0},
        '{OP_INSERT, 32'd1008, 1'b1, '{ST_NO_ROOM,   10'd0}},
        '{OP_SEARCH, 32'd1009, 1'b1, '{ST_NOT_FOUND, 10'd0}},
        '{OP_SEARCH, 32'd1007, 1'b0, '0},
        '{OP_INSERT, KEY_ALL,  1'b0, '0},
        '{OP_SEARCH, KEY_ALL,  1'b0, '0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    logic                    op = OP_INSERT;
    logic signed [KEY_W-1:0] key = '0;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    logic [STAT_W-1:0]       status;
    logic [SLOT_W-1:0]       slot;

    logic signed [KEY_W-1:0] node_key [TREE_SLOTS];
    logic [KEY_W-1:0]        stored_keys [$];
    pending_t                pending_verdicts [$];
    pending_t                oldest;

    int mismatches    = 0;
    int items_taken   = 0;
    int burst_left    = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    array_bst_insert_search_top #(
        .LEVELS(TREE_LEVELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .op(op),
        .key(key),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .slot(slot)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Walks the tree as the block does and updates it on a successful insert.
    function automatic verdict_t tree_walk(input logic walk_op, input logic [KEY_W-1:0] raw);
        int unsigned             pos;
        logic signed [KEY_W-1:0] probe;
        logic signed [KEY_W-1:0] here;
        verdict_t                v;
        probe = signed'(raw);
        pos = 0;
        while (pos < TREE_SLOTS)
        begin
            here = node_key[pos];
            if (here == 0)
            begin
                if (walk_op == OP_INSERT)
                begin
                    node_key[pos] = probe;
                    v.outcome = ST_INSERTED;
                    v.at_slot = pos[SLOT_W-1:0];
                end
                else
                begin
                    v.outcome = ST_NOT_FOUND;
                    v.at_slot = '0;
                end
                return v;
            end
            if (walk_op == OP_SEARCH && here == probe)
            begin
                v.outcome = ST_FOUND;
                v.at_slot = pos[SLOT_W-1:0];
                return v;
            end
            pos = (probe < here) ? 2 * pos + 1 : 2 * pos + 2;
        end
        v.outcome = (walk_op == OP_SEARCH) ? ST_NOT_FOUND : ST_NO_ROOM;
        v.at_slot = '0;
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Offers one item, opening a new burst with a gap in front when the last
    // one is used up, and records the expected result once it is taken.
    task automatic offer_item(input logic item_op, input logic [KEY_W-1:0] item_key,
                              input logic pinned, input verdict_t pinned_v);
        int       gap;
        verdict_t v;
        pending_t p;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 20);
        end
        burst_left--;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= item_op;
        key       <= item_key;
        do
            @(posedge clk);
        while (!req_ready);
        v = tree_walk(item_op, item_key);
        if (item_op == OP_INSERT && v.outcome == ST_INSERTED && item_key != 0)
            stored_keys.push_back(item_key);
        p.req_op  = item_op;
        p.req_key = item_key;
        p.want    = pinned ? pinned_v : v;
        pending_verdicts.push_back(p);
        items_taken++;
    endtask

    initial
    begin
        int               i;
        int               pick;
        logic             r_op;
        logic [KEY_W-1:0] r_key;
        for (i = 0; i < TREE_SLOTS; i++)
            node_key[i] = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
            offer_item(DIRECTED[i].req_op, DIRECTED[i].req_key,
                       DIRECTED[i].pinned, DIRECTED[i].want);
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            r_op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r_key = $urandom;
            else if (pick < 60)
                r_key = $urandom_range(0, 64) - 32;
            else if (pick < 85 && stored_keys.size() != 0)
                r_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (pick < 93 && stored_keys.size() != 0)
                r_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                        + $urandom_range(0, 2) - 1;
            else
                case ($urandom_range(0, 3))
                    0: r_key = KEY_MIN;
                    1: r_key = KEY_MAX;
                    2: r_key = KEY_ALL;
                    default: r_key = '0;
                endcase
            offer_item(r_op, r_key, 1'b0, '0);
        end
        req_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (TREE_LEVELS + 8) @(posedge clk);
        $display("Covered %0d requests (%0d from the directed table), %0d keys held in the tree.",
                 items_taken, N_DIRECTED, stored_keys.size());
        $display("Results: %0d inserted, %0d found, %0d not found, %0d with no room on the path.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Response pacing: stretches of steady acceptance and of random stalls,
    // plus one long hold-off that lets the block back up onto its input.
    initial
    begin
        int unsigned run_len;
        int unsigned mode;
        bit          held_off;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && items_taken >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(1, 40);
            repeat (run_len)
            begin
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            status_tally[status]++;
            if (pending_verdicts.size() == 0)
                flag_mismatch($sformatf("result status %0d slot %0d with no request pending",
                                        status, slot));
            else
            begin
                oldest = pending_verdicts.pop_front();
                if (status !== oldest.want.outcome)
                    flag_mismatch($sformatf("op %0d key %0d: status %0d, wanted %0d",
                                            oldest.req_op, signed'(oldest.req_key),
                                            status, oldest.want.outcome));
                if (slot !== oldest.want.at_slot)
                    flag_mismatch($sformatf("op %0d key %0d: slot %0d, wanted %0d",
                                            oldest.req_op, signed'(oldest.req_key),
                                            slot, oldest.want.at_slot));
            end
        end
    end

endmodule
